### hdl/scpd_pkg.sv
// shared types and constants for the serial command packet deframer
`default_nettype none

package scpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned QPTR_W   = 2;
  localparam int unsigned QDEPTH   = 1 << QPTR_W;
  localparam int unsigned QCNT_W   = QPTR_W + 1;

  localparam logic [BYTE_W-1:0] START_RST = 8'hDE;
  localparam logic [BYTE_W-1:0] READY_RST = 8'h00;
  localparam logic [BYTE_W-1:0] FAIL_RST  = 8'h00;
  localparam logic [BYTE_W-1:0] ID_RST    = 8'hFF;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE = 8'd0,
    CFG_READY_ID   = 8'd1,
    CFG_FAIL_ID    = 8'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_ID   = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_PAYLOAD = 3'd1,
    K_DONE    = 3'd2,
    K_READY   = 3'd3,
    K_FAIL    = 3'd4,
    K_REPLY   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    BEAT_START = 2'd0,
    BEAT_ID    = 2'd1,
    BEAT_ZERO  = 2'd2
  } beat_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic              reply;
    kind_t             kind;
    logic [BYTE_W-1:0] cmd_id;
    logic [BYTE_W-1:0] pkt_len;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] aux_byte;
    logic [BYTE_W-1:0] offset;
    logic              pkt_done;
    logic              ready_flag;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### hdl/serial_command_packet_deframer_core.sv
// top level of the serial command packet deframer
//
// usage:
//   input words (in_func, in_rx_byte) arrive on a valid/stall channel; a word
//   is taken when in_valid is high and in_stall is low. func 0 is a uart byte,
//   func 1 says software handled the pending packet
//   result words leave on out_* with the same valid/stall rule, one per
//   payload byte, header event or idle byte, three for a handled event
//   config writes (cfg_index 0 start byte, 1 ready id, 2 fail id) are taken
//   every cycle cfg_valid is high, cfg_ready is tied high; other indexes drop
// path: an accepted word enters the queue, then the output register
// throughput: one input word per cycle unless in_stall is high; a handled
//   event makes three result words, buffered by the four-word queue
// reset: rst_n low at a clock edge clears parser, queue and output valid,
//   restores register defaults (start byte 0xDE, ids 0x00)
// stall: when out_stall holds, the output register keeps its word, the queue
//   fills, and in_stall rises once the queue is full
`default_nettype none

module serial_command_packet_deframer_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [scpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scpd_pkg::BYTE_W-1:0]     cfg_data,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_func,
  input  wire logic [scpd_pkg::BYTE_W-1:0]     in_rx_byte,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [2:0]                           out_kind,
  output logic [scpd_pkg::BYTE_W-1:0]          out_cmd_id,
  output logic [scpd_pkg::BYTE_W-1:0]          out_pkt_len,
  output logic [scpd_pkg::BYTE_W-1:0]          out_data_byte,
  output logic [scpd_pkg::BYTE_W-1:0]          out_offset,
  output logic                                 out_pkt_done,
  output logic                                 out_ready_flag,
  output logic                                 out_last
);

  // front to queue
  logic              push;
  scpd_pkg::entry_t  push_ent;
  // queue to back
  scpd_pkg::entry_t  head;
  scpd_pkg::q_stat_t q_stat;
  logic              pop;

  // registers always accept a write
  assign cfg_ready = 1'b1;

  // parser: classifies each word and keeps packet state
  scpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .q_stat     (q_stat),
    .in_stall   (in_stall),
    .push       (push),
    .push_ent   (push_ent)
  );

  // decouples parser from the output side
  scpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // output sequencer: one word per queued event, three for a reply
  scpd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .out_stall      (out_stall),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_cmd_id     (out_cmd_id),
    .out_pkt_len    (out_pkt_len),
    .out_data_byte  (out_data_byte),
    .out_offset     (out_offset),
    .out_pkt_done   (out_pkt_done),
    .out_ready_flag (out_ready_flag),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

### hdl/scpd_front.sv
// front end: config registers, header parser and word classification
`default_nettype none

module scpd_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  input  wire logic [scpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [scpd_pkg::BYTE_W-1:0]          cfg_data,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_func,
  input  wire logic [scpd_pkg::BYTE_W-1:0]          in_rx_byte,
  input  wire scpd_pkg::q_stat_t                    q_stat,
  output logic                                      in_stall,
  output logic                                      push,
  output scpd_pkg::entry_t                          push_ent
);

  logic [scpd_pkg::BYTE_W-1:0] start_byte_r, ready_id_r, fail_id_r;

  scpd_pkg::phase_t            phase_r, phase_nxt;
  logic [scpd_pkg::BYTE_W-1:0] held_id_r, held_id_nxt;
  logic [scpd_pkg::BYTE_W-1:0] held_len_r, held_len_nxt;
  logic [scpd_pkg::BYTE_W-1:0] remaining_r, remaining_nxt;
  logic [scpd_pkg::BYTE_W-1:0] received_r, received_nxt;
  logic                        pkt_ready_r, pkt_ready_nxt;
  logic                        done;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= scpd_pkg::START_RST;
      ready_id_r   <= scpd_pkg::READY_RST;
      fail_id_r    <= scpd_pkg::FAIL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        scpd_pkg::CFG_START_BYTE: start_byte_r <= cfg_data;
        scpd_pkg::CFG_READY_ID:   ready_id_r   <= cfg_data;
        scpd_pkg::CFG_FAIL_ID:    fail_id_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    held_id_nxt   = held_id_r;
    held_len_nxt  = held_len_r;
    remaining_nxt = remaining_r;
    received_nxt  = received_r;
    pkt_ready_nxt = pkt_ready_r;
    done          = 1'b0;

    push_ent           = '0;
    push_ent.kind      = scpd_pkg::K_NONE;

    if (in_func) begin
      pkt_ready_nxt      = 1'b0;
      phase_nxt          = scpd_pkg::PH_WAIT;
      remaining_nxt      = '0;
      received_nxt       = '0;
      push_ent.reply     = 1'b1;
      push_ent.kind      = scpd_pkg::K_REPLY;
      push_ent.data_byte = start_byte_r;
      push_ent.aux_byte  = ready_id_r;
    end else begin
      case (phase_r)
        scpd_pkg::PH_WAIT: begin
          if (in_rx_byte == start_byte_r) phase_nxt = scpd_pkg::PH_ID;
        end
        scpd_pkg::PH_ID: begin
          held_id_nxt = in_rx_byte;
          phase_nxt   = scpd_pkg::PH_LEN;
        end
        scpd_pkg::PH_LEN: begin
          held_len_nxt = in_rx_byte;
          if (in_rx_byte == scpd_pkg::ZERO_BYTE &&
              (held_id_r == ready_id_r || held_id_r == fail_id_r)) begin
            // zero-length handshake, ready wins when both ids match
            phase_nxt     = scpd_pkg::PH_WAIT;
            push_ent.kind = (held_id_r == ready_id_r) ? scpd_pkg::K_READY
                                                      : scpd_pkg::K_FAIL;
          end else begin
            remaining_nxt = in_rx_byte;
            received_nxt  = '0;
            if (in_rx_byte == scpd_pkg::ZERO_BYTE) begin
              phase_nxt     = scpd_pkg::PH_WAIT;
              pkt_ready_nxt = 1'b1;
              push_ent.kind = scpd_pkg::K_DONE;
            end else begin
              phase_nxt = scpd_pkg::PH_DATA;
            end
          end
        end
        scpd_pkg::PH_DATA: begin
          done = (remaining_r <= 8'd1);
          push_ent.kind      = scpd_pkg::K_PAYLOAD;
          push_ent.data_byte = in_rx_byte;
          push_ent.offset    = received_r;
          push_ent.pkt_done  = done;
          if (done) begin
            phase_nxt     = scpd_pkg::PH_WAIT;
            remaining_nxt = '0;
            received_nxt  = '0;
            pkt_ready_nxt = 1'b1;
          end else begin
            remaining_nxt = remaining_r - 8'd1;
            received_nxt  = received_r + 8'd1;
          end
        end
        default: phase_nxt = scpd_pkg::PH_WAIT;
      endcase
    end

    push_ent.cmd_id     = held_id_nxt;
    push_ent.pkt_len    = held_len_nxt;
    push_ent.ready_flag = pkt_ready_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= scpd_pkg::PH_WAIT;
      held_id_r   <= scpd_pkg::ID_RST;
      held_len_r  <= '0;
      remaining_r <= '0;
      received_r  <= '0;
      pkt_ready_r <= 1'b0;
    end else if (push) begin
      phase_r     <= phase_nxt;
      held_id_r   <= held_id_nxt;
      held_len_r  <= held_len_nxt;
      remaining_r <= remaining_nxt;
      received_r  <= received_nxt;
      pkt_ready_r <= pkt_ready_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/scpd_queue.sv
// short flip-flop queue between parser and output sequencer
`default_nettype none

module scpd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire scpd_pkg::entry_t  push_ent,
  input  wire logic              pop,
  output scpd_pkg::entry_t       head,
  output scpd_pkg::q_stat_t      q_stat
);

  scpd_pkg::entry_t              ent_r [scpd_pkg::QDEPTH];
  logic [scpd_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [scpd_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign q_stat.full  = (count_r == scpd_pkg::QCNT_W'(scpd_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = ent_r[rd_ptr_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= scpd_pkg::QCNT_W'(scpd_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

`default_nettype wire

### hdl/scpd_back.sv
// back end: expands queued words into result words behind an output register
`default_nettype none

module scpd_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire scpd_pkg::entry_t              head,
  input  wire scpd_pkg::q_stat_t             q_stat,
  input  wire logic                          out_stall,
  output logic                               pop,
  output logic                               out_valid,
  output logic [2:0]                         out_kind,
  output logic [scpd_pkg::BYTE_W-1:0]        out_cmd_id,
  output logic [scpd_pkg::BYTE_W-1:0]        out_pkt_len,
  output logic [scpd_pkg::BYTE_W-1:0]        out_data_byte,
  output logic [scpd_pkg::BYTE_W-1:0]        out_offset,
  output logic                               out_pkt_done,
  output logic                               out_ready_flag,
  output logic                               out_last
);

  logic                        out_valid_r;
  scpd_pkg::beat_t             beat_r, beat_nxt;
  logic                        load;
  logic [scpd_pkg::BYTE_W-1:0] data_nxt;
  logic                        last_nxt;

  logic [2:0]                  kind_r;
  logic [scpd_pkg::BYTE_W-1:0] cmd_id_r, pkt_len_r, data_r, offset_r;
  logic                        pkt_done_r, ready_flag_r, last_r;

  assign load = (!out_valid_r || !out_stall) && !q_stat.empty;

  always_comb begin
    beat_nxt = beat_r;
    data_nxt = head.data_byte;
    last_nxt = 1'b1;
    pop      = load;
    if (head.reply) begin
      case (beat_r)
        scpd_pkg::BEAT_START: begin
          data_nxt = head.data_byte;
          last_nxt = 1'b0;
          pop      = 1'b0;
          if (load) beat_nxt = scpd_pkg::BEAT_ID;
        end
        scpd_pkg::BEAT_ID: begin
          data_nxt = head.aux_byte;
          last_nxt = 1'b0;
          pop      = 1'b0;
          if (load) beat_nxt = scpd_pkg::BEAT_ZERO;
        end
        scpd_pkg::BEAT_ZERO: begin
          data_nxt = scpd_pkg::ZERO_BYTE;
          if (load) beat_nxt = scpd_pkg::BEAT_START;
        end
        default: begin
          data_nxt = scpd_pkg::ZERO_BYTE;
          if (load) beat_nxt = scpd_pkg::BEAT_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= scpd_pkg::BEAT_START;
    end else begin
      beat_r <= beat_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r       <= head.kind;
      cmd_id_r     <= head.cmd_id;
      pkt_len_r    <= head.pkt_len;
      data_r       <= data_nxt;
      offset_r     <= head.offset;
      pkt_done_r   <= head.pkt_done;
      ready_flag_r <= head.ready_flag;
      last_r       <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_cmd_id     = cmd_id_r;
  assign out_pkt_len    = pkt_len_r;
  assign out_data_byte  = data_r;
  assign out_offset     = offset_r;
  assign out_pkt_done   = pkt_done_r;
  assign out_ready_flag = ready_flag_r;
  assign out_last       = last_r;

  a_beat_on_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r != scpd_pkg::BEAT_START) |-> (!q_stat.empty && head.reply))
    else $error("reply beat active without reply word at head");

  a_reply_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.reply) |-> (beat_r == scpd_pkg::BEAT_ZERO))
    else $error("reply word popped before its last byte");

endmodule

`default_nettype wire
